// File: rtl/core/cp1251u8_pkg.sv
package cp1251u8_pkg;

    localparam int unsigned CP_W = 16;

    localparam logic [CP_W-1:0] TWO_BYTE_LIMIT = 16'h0800;
    localparam logic [CP_W-1:0] ONE_BYTE_LIMIT = 16'h0080;

    localparam logic [7:0] LEAD2_MARK = 8'hC0;
    localparam logic [7:0] LEAD3_MARK = 8'hE0;
    localparam logic [7:0] CONT_MARK  = 8'h80;

    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    localparam logic [CP_W-1:0] HI_MAP [128] = '{
        16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
        16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'hFFFD, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
        16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
        16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
        16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457,
        16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
        16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
        16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
        16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F,
        16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0436, 16'h0437,
        16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F,
        16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
        16'h0448, 16'h0449, 16'h044A, 16'h044B, 16'h044C, 16'h044D, 16'h044E, 16'h044F
    };

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            last;
    } cp_item_t;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] len;
        logic       last;
    } enc_item_t;

endpackage

// File: rtl/core/cp1251u8_lookup.sv
module cp1251u8_lookup
    import cp1251u8_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_stall,
    input  logic [7:0] in_byte,
    input  logic     final_in,
    output logic     dst_valid,
    input  logic     dst_stall,
    output cp_item_t dst_item
);

    logic     valid_reg;
    logic     advance;
    cp_item_t item_reg;
    cp_item_t item_next;

    assign advance   = !valid_reg || !dst_stall;
    assign src_stall = !advance;

    always_comb
    begin
        item_next.last = final_in;
        if (in_byte[7] == 1'b0)
        begin
            item_next.cp = {8'h00, in_byte};
        end
        else
        begin
            item_next.cp = HI_MAP[in_byte[6:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && src_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign dst_valid = valid_reg;
    assign dst_item  = item_reg;

endmodule

// File: rtl/core/cp1251u8_encode.sv
module cp1251u8_encode
    import cp1251u8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  cp_item_t  src_item,
    output logic      dst_valid,
    input  logic      dst_stall,
    output enc_item_t dst_item
);

    logic      valid_reg;
    logic      advance;
    enc_item_t item_reg;
    enc_item_t item_next;

    assign advance   = !valid_reg || !dst_stall;
    assign src_stall = !advance;

    always_comb
    begin
        item_next.last = src_item.last;
        item_next.b1   = CONT_MARK | {2'b00, src_item.cp[5:0]};
        item_next.b2   = CONT_MARK | {2'b00, src_item.cp[5:0]};
        if (src_item.cp < ONE_BYTE_LIMIT)
        begin
            item_next.b0  = src_item.cp[7:0];
            item_next.len = LEN_ONE;
        end
        else if (src_item.cp < TWO_BYTE_LIMIT)
        begin
            item_next.b0  = LEAD2_MARK | {3'b000, src_item.cp[10:6]};
            item_next.len = LEN_TWO;
        end
        else
        begin
            item_next.b0  = LEAD3_MARK | {4'h0, src_item.cp[15:12]};
            item_next.b1  = CONT_MARK | {2'b00, src_item.cp[11:6]};
            item_next.len = LEN_THREE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && src_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign dst_valid = valid_reg;
    assign dst_item  = item_reg;

endmodule

// File: rtl/core/cp1251u8_serial.sv
module cp1251u8_serial
    import cp1251u8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  enc_item_t  src_item,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] out_byte,
    output logic       char_end,
    output logic       text_end
);

    logic       out_valid_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [7:0] buf1_reg;
    logic [7:0] buf2_reg;
    logic       last_reg;
    logic [7:0] byte_reg;
    logic       char_end_reg;
    logic       text_end_reg;
    logic       out_free;
    logic       take;
    logic       drain;

    assign out_free  = !out_valid_reg || !res_stall;
    assign drain     = out_free && (cnt_reg != 2'd0);
    assign take      = out_free && (cnt_reg == 2'd0) && src_valid;
    assign src_stall = !(out_free && (cnt_reg == 2'd0));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (drain)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
        else if (take)
        begin
            cnt_next = src_item.len - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (out_free)
            begin
                out_valid_reg <= drain || take;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            byte_reg     <= buf1_reg;
            char_end_reg <= (cnt_reg == 2'd1);
            text_end_reg <= (cnt_reg == 2'd1) && last_reg;
            buf1_reg     <= buf2_reg;
        end
        else if (take)
        begin
            byte_reg     <= src_item.b0;
            char_end_reg <= (src_item.len == LEN_ONE);
            text_end_reg <= (src_item.len == LEN_ONE) && src_item.last;
            buf1_reg     <= src_item.b1;
            buf2_reg     <= src_item.b2;
            last_reg     <= src_item.last;
        end
    end

    assign res_valid = out_valid_reg;
    assign out_byte  = byte_reg;
    assign char_end  = char_end_reg;
    assign text_end  = text_end_reg;

endmodule

// File: rtl/core/cp1251_to_utf8_encoder_core.sv
// Converts a stream of Windows-1251 bytes into UTF-8, one input byte per transfer and
// one UTF-8 byte per result transfer, lead byte first. A character gives one output
// byte when it is ASCII (0x00 to 0x7F), two when its code point is below U+0800, and
// three otherwise. The single-byte result register of the output serializer takes the
// next character only as the last byte of the current one leaves, so longer characters
// hold off input. The first byte of a character is registered in turn by the table
// lookup, encoding and serializer stages before it is presented. char_end marks the
// last byte of each character and text_end also marks it when the input byte came
// with final_in set.
module cp1251_to_utf8_encoder_core
    import cp1251u8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  logic [7:0] in_byte,
    input  logic       final_in,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] out_byte,
    output logic       char_end,
    output logic       text_end
);

    logic      cp_valid;
    logic      cp_stall;
    cp_item_t  cp_item;
    logic      enc_valid;
    logic      enc_stall;
    enc_item_t enc_item;

    cp1251u8_lookup u_lookup (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .in_byte   (in_byte),
        .final_in  (final_in),
        .dst_valid (cp_valid),
        .dst_stall (cp_stall),
        .dst_item  (cp_item)
    );

    cp1251u8_encode u_encode (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (cp_valid),
        .src_stall (cp_stall),
        .src_item  (cp_item),
        .dst_valid (enc_valid),
        .dst_stall (enc_stall),
        .dst_item  (enc_item)
    );

    cp1251u8_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (enc_valid),
        .src_stall (enc_stall),
        .src_item  (enc_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_byte  (out_byte),
        .char_end  (char_end),
        .text_end  (text_end)
    );

endmodule

// File: rtl/core/cp1251u8_checker.sv
module cp1251u8_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       src_valid,
    input logic       src_stall,
    input logic [7:0] in_byte,
    input logic       final_in,
    input logic       res_valid,
    input logic       res_stall,
    input logic [7:0] out_byte,
    input logic       char_end,
    input logic       text_end
);

    logic res_xfer;

    assign res_xfer = res_valid && !res_stall;

    a_src_hold: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_stall |=> src_valid && $stable(in_byte) && $stable(final_in))
        else $error("stalled input transfer changed");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(out_byte)
            && $stable(char_end) && $stable(text_end))
        else $error("stalled result transfer changed");

    a_text_end_char_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_xfer && text_end |-> char_end)
        else $error("text_end without char_end");

    a_lead_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_xfer && out_byte[7:6] == 2'b11 |-> !char_end)
        else $error("lead byte marked as character end");

    a_cont_follows: assert property (@(posedge clk) disable iff (!rst_n)
        res_xfer && out_byte[7:6] == 2'b11 ##1 res_valid |-> out_byte[7:6] == 2'b10)
        else $error("lead byte not followed by continuation byte");

endmodule

bind cp1251_to_utf8_encoder_core cp1251u8_checker u_cp1251u8_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .in_byte   (in_byte),
    .final_in  (final_in),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_byte  (out_byte),
    .char_end  (char_end),
    .text_end  (text_end)
);
